// ===== sv/fpfa_pkg.sv =====
package fpfa_pkg;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
	localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int CMD_W      = 2;
	localparam int BIDX_W     = 4;
	localparam int REQ_W      = 16;

	typedef struct packed {
		logic start;
		logic scan_en;
		logic out_load;
	} fpfa_cmd_t;

	typedef struct packed {
		logic scan_done;
	} fpfa_stat_t;

endpackage

// ===== sv/fixed_partition_fit_allocator.sv =====
// Fixed partition allocator with first, best and worst fit. Each item yields one
// result. A load, clear or unused-command result passes through the response state
// into the output register after its transfer in. An allocate walks the partitions
// 0 .. min(block_count, MAX_BLOCKS)-1 through the single read port of the size table,
// one partition per cycle, then goes through the response state into the output
// register. One item is in work at a time, and the next is taken in the cycle after
// the result is loaded. A stalled result holds the finished item until the output
// register frees up. No clearing pass after reset: partition sizes are undefined until
// loaded.
module fixed_partition_fit_allocator
	import fpfa_pkg::*;
#(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [BIDX_W-1:0]     block_index,
	input  logic [REQ_W-1:0]      item_size,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  granted,
	output logic [BIDX_W-1:0]     block_number
);

	fpfa_cmd_t  dp_cmd;
	fpfa_stat_t dp_stat;

	fpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	fpfa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.block_index  (block_index),
		.item_size    (item_size),
		.granted      (granted),
		.block_number (block_number),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat)
	);

endmodule

// ===== sv/fpfa_ctrl.sv =====
module fpfa_ctrl
	import fpfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] cmd,
	output logic             out_valid,
	input  logic             out_stall,
	output fpfa_cmd_t        dp_cmd,
	input  fpfa_stat_t       dp_stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign dp_cmd.start    = accept;
	assign dp_cmd.scan_en  = (state_q == ST_SCAN);
	assign dp_cmd.out_load = (state_q == ST_RESP) && out_free;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// drop the held result once it has been transferred
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cmd == CMD_ALLOC) ? ST_SCAN : ST_RESP;
					end
				end
				ST_SCAN: begin
					if (dp_stat.scan_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/fpfa_dp.sv =====
module fpfa_dp
	import fpfa_pkg::*;
#(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [BIDX_W-1:0]     block_index,
	input  logic [REQ_W-1:0]      item_size,
	output logic                  granted,
	output logic [BIDX_W-1:0]     block_number,
	input  fpfa_cmd_t             dp_cmd,
	output fpfa_stat_t            dp_stat
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int LIM_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
	localparam int CMP_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
	localparam int BI_W  = 7;

	logic [SIZE_BITS-1:0]  size_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] used_q;

	logic [1:0]            fit_mode_q;
	logic [CFG_DATA_W-1:0] block_count_q;

	logic [REQ_W-1:0]      req_q;
	logic [CNT_W-1:0]      scan_q;
	logic [CNT_W-1:0]      lim_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SIZE_BITS-1:0]  size_s1;

	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SIZE_BITS-1:0]  best_size_q;

	logic                  granted_q;
	logic [BIDX_W-1:0]     block_number_q;

	logic [LIM_W-1:0]      count_ext;
	logic [LIM_W-1:0]      limit;
	logic                  issue;
	logic                  load_ok;
	logic                  fits;
	logic                  take;

	assign cfg_ready = 1'b1;

	assign count_ext = LIM_W'(block_count_q);
	assign limit     = (count_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : count_ext;
	assign issue     = dp_cmd.scan_en && (scan_q < lim_q);
	assign load_ok   = BI_W'(block_index) < BI_W'(MAX_BLOCKS);

	assign fits = vld_s1 && !used_q[idx_s1] && (CMP_W'(size_s1) >= CMP_W'(req_q));

	always_comb begin
		take = 1'b0;
		if (fits) begin
			priority if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == MODE_BEST) begin
				take = size_s1 < best_size_q;
			end else if (fit_mode_q == MODE_WORST) begin
				take = size_s1 > best_size_q;
			end else begin
				take = 1'b0;
			end
		end
	end

	assign dp_stat.scan_done = (scan_q >= lim_q) && !vld_s1;

	assign granted      = granted_q;
	assign block_number = block_number_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_FIRST;
			block_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_FIT_MODE) begin
				fit_mode_q <= cfg_data[1:0];
			end else if (cfg_index == CFG_BLOCK_COUNT) begin
				block_count_q <= cfg_data;
			end
		end
	end

	// size table: one write port at accept, one read port for the scan
	always_ff @(posedge clk) begin
		if (dp_cmd.start && (cmd == CMD_LOAD) && load_ok) begin
			size_mem[IDX_W'(block_index)] <= SIZE_BITS'(item_size);
		end
		if (issue) begin
			size_s1 <= size_mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (dp_cmd.start && (cmd == CMD_CLEAR)) begin
				used_q <= '0;
			end else if (dp_cmd.out_load && found_q) begin
				used_q[best_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			lim_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (dp_cmd.start) begin
				scan_q  <= '0;
				lim_q   <= CNT_W'(limit);
				vld_s1  <= 1'b0;
				found_q <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					scan_q <= scan_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			req_q <= item_size;
		end
		if (issue) begin
			idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (take) begin
			best_idx_q  <= idx_s1;
			best_size_q <= size_s1;
		end
		if (dp_cmd.out_load) begin
			granted_q      <= found_q;
			block_number_q <= found_q ? BIDX_W'(best_idx_q) : '0;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import fpfa_pkg::*;

	localparam int NUM_PARTS = 2 ** BIDX_W;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

	typedef struct packed {
		logic              granted;
		logic [BIDX_W-1:0] block_number;
	} grant_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [CMD_W-1:0]      cmd;
	logic [BIDX_W-1:0]     block_index;
	logic [REQ_W-1:0]      item_size;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  granted;
	logic [BIDX_W-1:0]     block_number;

	// allocator state as the testbench sees it
	logic [REQ_W-1:0]      part_size [NUM_PARTS];
	logic                  part_used [NUM_PARTS];
	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] count_q;
	logic [1:0]            fit_order [4];

	grant_t grant_queue [$];
	int     error_count = 0;
	bit     calm = 1'b0;

	fixed_partition_fit_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.block_index  (block_index),
		.item_size    (item_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.block_number (block_number)
	);

	always #10 clk = ~clk;

	initial begin
		#30_000_000;
		$display("testbench: errors");
		$finish;
	end

	task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
	                            input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_FIT_MODE:    mode_q = data[1:0];
			CFG_BLOCK_COUNT: count_q = data;
			default: ;
		endcase
	endtask

	// update the partition table for one item and queue the grant it yields
	task automatic advance_allocator(input logic [CMD_W-1:0] c, input logic [BIDX_W-1:0] bi,
	                                 input logic [REQ_W-1:0] sz);
		grant_t           res;
		int               limit;
		bit               found;
		logic [REQ_W-1:0] pick_size;
		res = '0;
		case (c)
			CMD_LOAD: part_size[bi] = sz;
			CMD_ALLOC: begin
				limit = (count_q > NUM_PARTS) ? NUM_PARTS : int'(count_q);
				found = 1'b0;
				pick_size = '0;
				for (int j = 0; j < limit; j++) begin
					if (!part_used[j] && part_size[j] >= sz) begin
						// first fit keeps the first hit; unused mode acts the same
						if (!found) begin
							found = 1'b1;
							res.block_number = j[BIDX_W-1:0];
							pick_size = part_size[j];
						end else if (mode_q == MODE_BEST && part_size[j] < pick_size) begin
							res.block_number = j[BIDX_W-1:0];
							pick_size = part_size[j];
						end else if (mode_q == MODE_WORST && part_size[j] > pick_size) begin
							res.block_number = j[BIDX_W-1:0];
							pick_size = part_size[j];
						end
					end
				end
				if (found) begin
					res.granted = 1'b1;
					part_used[res.block_number] = 1'b1;
				end
			end
			CMD_CLEAR: begin
				for (int k = 0; k < NUM_PARTS; k++)
					part_used[k] = 1'b0;
			end
			default: ;
		endcase
		grant_queue.push_back(res);
	endtask

	task automatic check_result;
		grant_t want;
		if (grant_queue.size() == 0) begin
			$error("unexpected result: granted %0d block_number %0d", granted, block_number);
			error_count++;
		end else begin
			want = grant_queue.pop_front();
			if (granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, granted);
				error_count++;
			end
			if (block_number !== want.block_number) begin
				$error("block_number: expected %0d, got %0d", want.block_number, block_number);
				error_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			out_stall <= !calm && ($urandom_range(0, 99) < 34);
		end
	end

	function automatic logic [REQ_W-1:0] rand_size();
		logic [REQ_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2, 3, 4, 5: v = REQ_W'($urandom_range(0, 255));
			default: v = REQ_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [BIDX_W-1:0] bi,
	                         input logic [REQ_W-1:0] sz);
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		block_index <= bi;
		item_size   <= sz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_allocator(c, bi, sz);
	endtask

	// hold off input until every queued grant has come back
	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (grant_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_config(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// reset config: nothing to search, so no grant
	task automatic test_reset_defaults;
		send_item(CMD_ALLOC, '0, '0);
		send_item(CMD_SPARE, '1, '1);
		send_item(CMD_CLEAR, 4'd9, 16'h1234);
	endtask

	task automatic test_partition_load;
		send_item(CMD_LOAD, 4'd0, 16'd100);
		send_item(CMD_LOAD, 4'd1, 16'hFFFF);
		send_item(CMD_LOAD, 4'd2, 16'd0);
		send_item(CMD_LOAD, 4'd3, 16'd50);
		send_item(CMD_LOAD, 4'd4, 16'd100);
	endtask

	// partitions 0 and 4 tie at 100, so best and worst fit must take the lower index
	task automatic test_fit_modes;
		wait_drained;
		write_reg(CFG_BLOCK_COUNT, 5'd5);
		for (int m = 0; m < 4; m++) begin
			wait_drained;
			write_reg(CFG_FIT_MODE, {3'b000, fit_order[m]});
			send_item(CMD_CLEAR, '0, '0);
			send_item(CMD_ALLOC, 4'd7, 16'd50);
			send_item(CMD_ALLOC, 4'd15, 16'd50);
			send_item(CMD_ALLOC, 4'd0, 16'hFFFF);
		end
	endtask

	task automatic test_random_traffic;
		int counts [10];
		int r;
		counts = '{16, 31, 1, 0, 8, 17, 16, 3, 12, 16};
		wait_drained;
		write_reg(CFG_UNMAPPED_A, 5'h1F);
		write_reg(CFG_UNMAPPED_B, 5'h0A);
		for (int p = 0; p < 10; p++) begin
			wait_drained;
			write_reg(CFG_FIT_MODE, {3'b000, fit_order[p % 4]});
			write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(counts[p]));
			calm = (p == 4);
			// fill the whole table before any wide search can reach it
			if (p == 0) begin
				for (int k = 0; k < NUM_PARTS; k++)
					send_item(CMD_LOAD, BIDX_W'(k), rand_size());
			end
			for (int n = 0; n < 125; n++) begin
				if (p == 2 && n == 60)
					wait_drained;
				r = $urandom_range(0, 99);
				if (r < 50)
					send_item(CMD_ALLOC, BIDX_W'($urandom), rand_size());
				else if (r < 72)
					send_item(CMD_LOAD, BIDX_W'($urandom), rand_size());
				else if (r < 92)
					send_item(CMD_CLEAR, BIDX_W'($urandom), REQ_W'($urandom));
				else
					send_item(CMD_SPARE, BIDX_W'($urandom), REQ_W'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		cmd         <= '0;
		block_index <= '0;
		item_size   <= '0;
		fit_order[0] = MODE_FIRST;
		fit_order[1] = MODE_BEST;
		fit_order[2] = MODE_WORST;
		fit_order[3] = MODE_SPARE;
		for (int k = 0; k < NUM_PARTS; k++)
			part_used[k] = 1'b0;
		mode_q = MODE_FIRST;
		count_q = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_partition_load();
		test_fit_modes();
		test_random_traffic();

		wait_drained;
		repeat (25) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
